// ----- rtl/wsmp_pkg.sv -----
// Shared types, codes and constants for the WSMP header parser.
package wsmp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned PSID_W    = 32;
    localparam int unsigned PSID_LEN_W = 3;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned LIMIT_W   = 6;
    localparam int unsigned PAYLEN_W  = 16;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0]  WAVE_ID_RESET = 8'd128;
    localparam logic [BYTE_W-1:0]  CHANNEL_RESET = 8'd15;
    localparam logic [BYTE_W-1:0]  RATE_RESET    = 8'd16;
    localparam logic [BYTE_W-1:0]  POWER_RESET   = 8'd4;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 6'd20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WAVE_ID = 3'd0,
        CFG_CHANNEL = 3'd1,
        CFG_RATE    = 3'd2,
        CFG_POWER   = 3'd3,
        CFG_LIMIT   = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PSID  = 2'd1,
        ST_NO_WAVE   = 2'd2,
        ST_SHORT     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PSID    = 3'd1,
        PH_SCAN    = 3'd2,
        PH_ELEMLEN = 3'd3,
        PH_ELEMVAL = 3'd4,
        PH_LENHI   = 3'd5,
        PH_LENLO   = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        PEND_NONE  = 2'd0,
        PEND_CHAN  = 2'd1,
        PEND_RATE  = 2'd2,
        PEND_POWER = 2'd3
    } pending_t;

    // PSID length from the prefix bits of its first byte, 0 for a bad prefix.
    function automatic logic [PSID_LEN_W-1:0] psid_prefix_len(input logic [BYTE_W-1:0] b);
        logic [PSID_LEN_W-1:0] n;
        if ((b & 8'hF0) == 8'hE0) begin
            n = 3'd4;
        end else if ((b & 8'hE0) == 8'hC0) begin
            n = 3'd3;
        end else if ((b & 8'hC0) == 8'h80) begin
            n = 3'd2;
        end else if ((b & 8'h80) == 8'h00) begin
            n = 3'd1;
        end else begin
            n = 3'd0;
        end
        return n;
    endfunction

endpackage

// ----- rtl/wsmp_header_parser.sv -----
// WSMP header parser: byte-serial decoder of the WAVE short message header.
//
// Takes one frame byte per transfer and may take a byte in every cycle; the
// state update for a byte is done in the cycle it is taken, and a result is
// registered in the output stage, so a byte can be taken while a result still
// waits (input stalls only when the output register is full and not drained).
// A byte with frame_first restarts the parser and is the version byte; the PSID
// (1 to 4 bytes by prefix), the element scan and the 16-bit payload length
// follow. At most one result is given per frame, when the header completes or
// fails, none if a new frame_first cuts it short; later bytes up to the next
// frame_first are dropped. Channel, rate and power read as zero if their
// elements are absent. Configuration writes take effect on the next byte.
module wsmp_header_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [wsmp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [wsmp_pkg::BYTE_W-1:0]         cfg_wr_data,
    // byte input
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [wsmp_pkg::BYTE_W-1:0]         s_data_byte,
    input  logic                                s_frame_first,
    input  logic                                s_frame_last,
    // header result
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [1:0]                          m_status,
    output logic [wsmp_pkg::BYTE_W-1:0]         m_version,
    output logic [wsmp_pkg::PSID_W-1:0]         m_psid_value,
    output logic [wsmp_pkg::PSID_LEN_W-1:0]     m_psid_length,
    output logic [wsmp_pkg::BYTE_W-1:0]         m_channel_number,
    output logic [wsmp_pkg::BYTE_W-1:0]         m_data_rate,
    output logic signed [wsmp_pkg::BYTE_W-1:0]  m_tx_power,
    output logic [wsmp_pkg::PAYLEN_W-1:0]       m_payload_length,
    output logic [wsmp_pkg::POS_W-1:0]          m_header_length
);
    import wsmp_pkg::*;

    // configuration registers
    logic [BYTE_W-1:0]  wave_id_reg, channel_id_reg, rate_id_reg, power_id_reg;
    logic [LIMIT_W-1:0] scan_limit_reg;

    // parser state
    phase_t                phase_reg, phase_next;
    pending_t              pending_reg, pending_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [PSID_LEN_W-1:0] left_reg, left_next;
    logic [PSID_LEN_W-1:0] psid_len_reg, psid_len_next;
    logic [PSID_W-1:0]     psid_reg, psid_next;
    logic [BYTE_W-1:0]     version_reg, version_next;
    logic [BYTE_W-1:0]     channel_reg, channel_next;
    logic [BYTE_W-1:0]     rate_reg, rate_next;
    logic [BYTE_W-1:0]     power_reg, power_next;
    logic [BYTE_W-1:0]     len_high_reg, len_high_next;

    // output stage
    logic                  m_valid_reg;
    status_t               m_status_reg;
    logic [BYTE_W-1:0]     m_version_reg, m_channel_reg, m_rate_reg;
    logic signed [BYTE_W-1:0] m_power_reg;
    logic [PSID_W-1:0]     m_psid_reg;
    logic [PSID_LEN_W-1:0] m_psid_len_reg;
    logic [PAYLEN_W-1:0]   m_payload_reg;
    logic [POS_W-1:0]      m_hdr_len_reg;

    // decode
    logic                  s_accept;
    logic [POS_W:0]        next_pos;
    logic                  limit_hit;
    logic                  is_wave, is_chan, is_rate, is_power;
    logic [PSID_LEN_W-1:0] prefix_len;
    logic [PSID_LEN_W-1:0] left_upd;
    logic                  emit;
    status_t               emit_status;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign next_pos   = {1'b0, pos_reg} + {{POS_W{1'b0}}, 1'b1};
    assign limit_hit  = next_pos > {{(POS_W+1-LIMIT_W){1'b0}}, scan_limit_reg};
    assign is_wave    = s_data_byte == wave_id_reg;
    assign is_chan    = s_data_byte == channel_id_reg;
    assign is_rate    = s_data_byte == rate_id_reg;
    assign is_power   = s_data_byte == power_id_reg;
    assign prefix_len = psid_prefix_len(s_data_byte);
    assign left_upd   = (psid_len_reg == '0) ? prefix_len - 3'd1 : left_reg - 3'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_id_reg    <= WAVE_ID_RESET;
            channel_id_reg <= CHANNEL_RESET;
            rate_id_reg    <= RATE_RESET;
            power_id_reg   <= POWER_RESET;
            scan_limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WAVE_ID: wave_id_reg    <= cfg_wr_data;
                CFG_CHANNEL: channel_id_reg <= cfg_wr_data;
                CFG_RATE:    rate_id_reg    <= cfg_wr_data;
                CFG_POWER:   power_id_reg   <= cfg_wr_data;
                CFG_LIMIT:   scan_limit_reg <= cfg_wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // next phase and result decision
    always_comb begin
        phase_next  = phase_reg;
        emit        = 1'b0;
        emit_status = ST_OK;
        if (s_accept) begin
            if (s_frame_first) begin
                phase_next = PH_PSID;
                if (s_frame_last) begin
                    emit        = 1'b1;
                    emit_status = ST_SHORT;
                end
            end else begin
                unique case (phase_reg)
                    PH_IDLE: ;
                    PH_PSID: begin
                        if (psid_len_reg == '0 && prefix_len == '0) begin
                            emit        = 1'b1;
                            emit_status = ST_BAD_PSID;
                        end else if (left_upd == '0) begin
                            phase_next = PH_SCAN;
                        end
                    end
                    PH_SCAN: begin
                        if (is_wave) begin
                            phase_next = PH_LENHI;
                        end else if (is_chan || is_rate || is_power) begin
                            phase_next = PH_ELEMLEN;
                        end else if (limit_hit) begin
                            emit        = 1'b1;
                            emit_status = ST_NO_WAVE;
                        end
                    end
                    PH_ELEMLEN: phase_next = PH_ELEMVAL;
                    PH_ELEMVAL: begin
                        phase_next = PH_SCAN;
                        if (limit_hit) begin
                            emit        = 1'b1;
                            emit_status = ST_NO_WAVE;
                        end
                    end
                    PH_LENHI: phase_next = PH_LENLO;
                    PH_LENLO: begin
                        emit        = 1'b1;
                        emit_status = ST_OK;
                    end
                    default: phase_next = PH_IDLE;
                endcase
                if (phase_reg != PH_IDLE && !emit && s_frame_last) begin
                    emit        = 1'b1;
                    emit_status = ST_SHORT;
                end
            end
            if (emit) begin
                phase_next = PH_IDLE;
            end
        end
    end

    // field registers
    always_comb begin
        pos_next      = pos_reg;
        left_next     = left_reg;
        pending_next  = pending_reg;
        version_next  = version_reg;
        psid_next     = psid_reg;
        psid_len_next = psid_len_reg;
        channel_next  = channel_reg;
        rate_next     = rate_reg;
        power_next    = power_reg;
        len_high_next = len_high_reg;
        if (s_accept) begin
            if (s_frame_first) begin
                pos_next      = {{(POS_W-1){1'b0}}, 1'b1};
                left_next     = '0;
                pending_next  = PEND_NONE;
                version_next  = s_data_byte;
                psid_next     = '0;
                psid_len_next = '0;
                channel_next  = '0;
                rate_next     = '0;
                power_next    = '0;
                len_high_next = '0;
            end else if (phase_reg != PH_IDLE) begin
                pos_next = next_pos[POS_W-1:0];
                case (phase_reg)
                    PH_PSID: begin
                        if (psid_len_reg == '0) begin
                            if (prefix_len != '0) begin
                                psid_len_next = prefix_len;
                                psid_next     = {{(PSID_W-BYTE_W){1'b0}}, s_data_byte};
                                left_next     = left_upd;
                            end
                        end else begin
                            psid_next = {psid_reg[PSID_W-BYTE_W-1:0], s_data_byte};
                            left_next = left_upd;
                        end
                    end
                    PH_SCAN: begin
                        if (!is_wave) begin
                            if (is_chan) begin
                                pending_next = PEND_CHAN;
                            end else if (is_rate) begin
                                pending_next = PEND_RATE;
                            end else if (is_power) begin
                                pending_next = PEND_POWER;
                            end
                        end
                    end
                    PH_ELEMVAL: begin
                        case (pending_reg)
                            PEND_CHAN:  channel_next = s_data_byte;
                            PEND_RATE:  rate_next    = s_data_byte;
                            PEND_POWER: power_next   = s_data_byte;
                            default: ;
                        endcase
                        pending_next = PEND_NONE;
                    end
                    PH_LENHI: len_high_next = s_data_byte;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pending_reg  <= PEND_NONE;
            pos_reg      <= '0;
            left_reg     <= '0;
            psid_len_reg <= '0;
            psid_reg     <= '0;
            version_reg  <= '0;
            channel_reg  <= '0;
            rate_reg     <= '0;
            power_reg    <= '0;
            len_high_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            pos_reg      <= pos_next;
            left_reg     <= left_next;
            psid_len_reg <= psid_len_next;
            psid_reg     <= psid_next;
            version_reg  <= version_next;
            channel_reg  <= channel_next;
            rate_reg     <= rate_next;
            power_reg    <= power_next;
            len_high_reg <= len_high_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result register: load with the field values as updated by this byte
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_status_reg   <= emit_status;
            m_version_reg  <= version_next;
            m_psid_reg     <= psid_next;
            m_psid_len_reg <= psid_len_next;
            m_channel_reg  <= channel_next;
            m_rate_reg     <= rate_next;
            m_power_reg    <= signed'(power_next);
            if (emit_status == ST_OK) begin
                m_payload_reg <= {len_high_reg, s_data_byte};
                m_hdr_len_reg <= next_pos[POS_W-1:0];
            end else begin
                m_payload_reg <= '0;
                m_hdr_len_reg <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_version        = m_version_reg;
    assign m_psid_value     = m_psid_reg;
    assign m_psid_length    = m_psid_len_reg;
    assign m_channel_number = m_channel_reg;
    assign m_data_rate      = m_rate_reg;
    assign m_tx_power       = m_power_reg;
    assign m_payload_length = m_payload_reg;
    assign m_header_length  = m_hdr_len_reg;

    a_fail_no_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg != ST_OK)
            |-> (m_hdr_len_reg == '0 && m_payload_reg == '0))
        else $error("failed header carries a length");

    a_bad_psid_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_BAD_PSID)
            |-> (m_psid_len_reg == '0 && m_psid_reg == '0))
        else $error("bad PSID result carries PSID bytes");

    a_ok_has_psid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == ST_OK)
            |-> (m_psid_len_reg != '0 && m_hdr_len_reg > 7'd4))
        else $error("successful header without PSID");

    a_psid_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (left_reg < 3'd4) && (psid_len_reg <= 3'd4))
        else $error("PSID byte count out of range");

    a_emit_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready)
            |=> (m_valid_reg && $stable(m_psid_reg) && $stable(m_status_reg)))
        else $error("held result overwritten");

endmodule

// ----- bench/tb_wsmp_header_parser.sv -----
// Self-checking testbench for the WSMP header parser: byte stream in, header results checked.
module tb_wsmp_header_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import wsmp_pkg::*;

    localparam int CYCLE_LIMIT   = 400_000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       first;
        logic       last;
    } frame_byte_t;

    typedef struct {
        status_t           status;
        logic [7:0]        version;
        logic [31:0]       psid;
        logic [2:0]        psid_len;
        logic [7:0]        channel;
        logic [7:0]        rate;
        logic signed [7:0] power;
        logic [15:0]       payload_len;
        logic [6:0]        header_len;
    } hdr_result_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = CFG_WAVE_ID;
    logic [BYTE_W-1:0]      cfg_wr_data = '0;

    logic                   s_valid       = 1'b0;
    logic                   s_ready;
    logic [BYTE_W-1:0]      s_data_byte   = '0;
    logic                   s_frame_first = 1'b0;
    logic                   s_frame_last  = 1'b0;

    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_status;
    logic [BYTE_W-1:0]      m_version;
    logic [PSID_W-1:0]      m_psid_value;
    logic [PSID_LEN_W-1:0]  m_psid_length;
    logic [BYTE_W-1:0]      m_channel_number;
    logic [BYTE_W-1:0]      m_data_rate;
    logic signed [BYTE_W-1:0] m_tx_power;
    logic [PAYLEN_W-1:0]    m_payload_length;
    logic [POS_W-1:0]       m_header_length;

    wsmp_header_parser i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_frame_first    (s_frame_first),
        .s_frame_last     (s_frame_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_version        (m_version),
        .m_psid_value     (m_psid_value),
        .m_psid_length    (m_psid_length),
        .m_channel_number (m_channel_number),
        .m_data_rate      (m_data_rate),
        .m_tx_power       (m_tx_power),
        .m_payload_length (m_payload_length),
        .m_header_length  (m_header_length)
    );

    // Shadow copy of the configuration registers
    logic [7:0] cfg_wave  = WAVE_ID_RESET;
    logic [7:0] cfg_chan  = CHANNEL_RESET;
    logic [7:0] cfg_rate  = RATE_RESET;
    logic [7:0] cfg_power = POWER_RESET;
    logic [5:0] cfg_limit = LIMIT_RESET;

    // Parser state as predicted
    phase_t      hdr_phase     = PH_IDLE;
    logic [6:0]  hdr_pos       = '0;
    logic [2:0]  hdr_psid_left = '0;
    pending_t    hdr_pending   = PEND_NONE;
    logic [7:0]  hdr_version   = '0;
    logic [31:0] hdr_psid      = '0;
    logic [2:0]  hdr_psid_len  = '0;
    logic [7:0]  hdr_channel   = '0;
    logic [7:0]  hdr_rate      = '0;
    logic [7:0]  hdr_power     = '0;
    logic [7:0]  hdr_len_high  = '0;

    frame_byte_t  byte_q[$];
    hdr_result_t  header_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int frame_bytes_queued = 0;
    int bytes_taken    = 0;
    int headers_seen   = 0;
    int mismatches     = 0;
    int cycle_count    = 0;
    int status_count[4];

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d headers outstanding",
                     cycle_count, header_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [2:0] psid_size_of(input logic [7:0] b);
        casez (b)
            8'b1110_????: return 3'd4;
            8'b110?_????: return 3'd3;
            8'b10??_????: return 3'd2;
            8'b0???_????: return 3'd1;
            default:      return 3'd0;
        endcase
    endfunction

    task automatic close_header(input status_t st, input logic [15:0] plen,
                                input logic [6:0] hlen);
        hdr_result_t h;
        h.status      = st;
        h.version     = hdr_version;
        h.psid        = hdr_psid;
        h.psid_len    = hdr_psid_len;
        h.channel     = hdr_channel;
        h.rate        = hdr_rate;
        h.power       = hdr_power;
        h.payload_len = plen;
        h.header_len  = hlen;
        header_q.push_back(h);
        hdr_phase = PH_IDLE;
    endtask

    // Advance the predicted parser by one transferred byte
    task automatic decode_byte(input logic [7:0] d, input logic first, input logic last);
        int         nxt;
        logic [2:0] n;
        if (first) begin
            hdr_pos       = 7'd1;
            hdr_psid_left = '0;
            hdr_pending   = PEND_NONE;
            hdr_version   = d;
            hdr_psid      = '0;
            hdr_psid_len  = '0;
            hdr_channel   = '0;
            hdr_rate      = '0;
            hdr_power     = '0;
            hdr_len_high  = '0;
            hdr_phase     = PH_PSID;
            if (last) close_header(ST_SHORT, '0, '0);
            return;
        end
        if (hdr_phase == PH_IDLE) return;
        nxt     = int'(hdr_pos) + 1;
        hdr_pos = hdr_pos + 7'd1;
        case (hdr_phase)
            PH_PSID: begin
                if (hdr_psid_len == 0) begin
                    n = psid_size_of(d);
                    if (n == 0) begin
                        hdr_psid = '0;
                        close_header(ST_BAD_PSID, '0, '0);
                        return;
                    end
                    hdr_psid_len  = n;
                    hdr_psid      = {24'd0, d};
                    hdr_psid_left = n - 3'd1;
                end else begin
                    hdr_psid      = {hdr_psid[23:0], d};
                    hdr_psid_left = hdr_psid_left - 3'd1;
                end
                if (hdr_psid_left == 0) hdr_phase = PH_SCAN;
            end
            PH_SCAN: begin
                // wave ID wins over the others, then channel, rate, power
                if (d == cfg_wave) begin
                    hdr_phase = PH_LENHI;
                end else if (d == cfg_chan) begin
                    hdr_pending = PEND_CHAN;
                    hdr_phase   = PH_ELEMLEN;
                end else if (d == cfg_rate) begin
                    hdr_pending = PEND_RATE;
                    hdr_phase   = PH_ELEMLEN;
                end else if (d == cfg_power) begin
                    hdr_pending = PEND_POWER;
                    hdr_phase   = PH_ELEMLEN;
                end else if (nxt > int'(cfg_limit)) begin
                    close_header(ST_NO_WAVE, '0, '0);
                    return;
                end
            end
            PH_ELEMLEN: begin
                hdr_phase = PH_ELEMVAL;
            end
            PH_ELEMVAL: begin
                case (hdr_pending)
                    PEND_CHAN:  hdr_channel = d;
                    PEND_RATE:  hdr_rate    = d;
                    PEND_POWER: hdr_power   = d;
                    default:    ;
                endcase
                hdr_pending = PEND_NONE;
                hdr_phase   = PH_SCAN;
                // limit beats frame end when both hit on this byte
                if (nxt > int'(cfg_limit)) begin
                    close_header(ST_NO_WAVE, '0, '0);
                    return;
                end
            end
            PH_LENHI: begin
                hdr_len_high = d;
                hdr_phase    = PH_LENLO;
            end
            PH_LENLO: begin
                close_header(ST_OK, {hdr_len_high, d}, 7'(nxt));
                return;
            end
            default: begin
                hdr_phase = PH_IDLE;
                return;
            end
        endcase
        if (last) close_header(ST_SHORT, '0, '0);
    endtask

    // Byte driver: hold the transfer until accepted, then load the next pending byte
    always @(posedge aclk) begin : drive_bytes
        frame_byte_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_frame_first, s_frame_last);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    item = byte_q.pop_front();
                    s_valid       <= 1'b1;
                    s_data_byte   <= item.data;
                    s_frame_first <= item.first;
                    s_frame_last  <= item.last;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] expected,
                                        input logic [31:0] actual);
        if (actual !== expected) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
            mismatches++;
        end
    endfunction

    // Result monitor: compare each transfer with the oldest predicted header
    always @(posedge aclk) begin : check_headers
        hdr_result_t exp_hdr;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid === 1'b1 && m_ready) begin
                if (header_q.size() == 0) begin
                    $error("header result with none predicted, status %0d", m_status);
                    mismatches++;
                end else begin
                    exp_hdr = header_q.pop_front();
                    headers_seen++;
                    status_count[exp_hdr.status]++;
                    check_field("status", exp_hdr.status, m_status);
                    check_field("version", exp_hdr.version, m_version);
                    check_field("psid_value", exp_hdr.psid, m_psid_value);
                    check_field("psid_length", exp_hdr.psid_len, m_psid_length);
                    check_field("channel_number", exp_hdr.channel, m_channel_number);
                    check_field("data_rate", exp_hdr.rate, m_data_rate);
                    check_field("tx_power", exp_hdr.power, m_tx_power);
                    check_field("payload_length", exp_hdr.payload_len, m_payload_length);
                    check_field("header_length", exp_hdr.header_len, m_header_length);
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic add_byte(input logic [7:0] d, input logic first, input logic last);
        frame_byte_t item;
        item.data  = d;
        item.first = first;
        item.last  = last;
        byte_q.push_back(item);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= value;
        case (idx)
            CFG_WAVE_ID: cfg_wave  = value;
            CFG_CHANNEL: cfg_chan  = value;
            CFG_RATE:    cfg_rate  = value;
            CFG_POWER:   cfg_power = value;
            CFG_LIMIT:   cfg_limit = value[5:0];
            default:     ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] wave, input logic [7:0] chan,
                               input logic [7:0] rate, input logic [7:0] power,
                               input logic [5:0] limit);
        write_reg(CFG_WAVE_ID, wave);
        write_reg(CFG_CHANNEL, chan);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_POWER, power);
        write_reg(CFG_LIMIT, {2'b00, limit});
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every byte is transferred and every header checked, then let the block settle
    task automatic wait_drained();
        do @(negedge aclk); while (byte_q.size() != 0 || s_valid || header_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Queue one frame: mostly well formed, some truncated, overrunning or with a bad prefix
    task automatic push_frame();
        logic [7:0] fb[$];
        logic [7:0] v;
        int  roll, n, cur, elems, cut;
        bit  overrun, mark_last;
        roll    = $urandom_range(99);
        overrun = (roll >= 82 && roll < 92);
        // stray bytes between frames
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 3))
                add_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
        fb.push_back(8'($urandom_range(255)));
        n = $urandom_range(1, 4);
        case (n)
            1:       fb.push_back({1'b0, 7'($urandom_range(127))});
            2:       fb.push_back({2'b10, 6'($urandom_range(63))});
            3:       fb.push_back({3'b110, 5'($urandom_range(31))});
            default: fb.push_back({4'b1110, 4'($urandom_range(15))});
        endcase
        for (int i = 1; i < n; i++) fb.push_back(8'($urandom_range(255)));
        if (roll >= 92) fb[1] = {4'hF, 4'($urandom_range(15))};
        cur   = n + 1;
        elems = $urandom_range(0, 4);
        for (int i = 0; i < elems || (overrun && cur <= int'(cfg_limit) + 1); i++) begin
            if ($urandom_range(2) != 0 && (overrun || cur + 3 <= int'(cfg_limit))) begin
                case ($urandom_range(2))
                    0:       v = cfg_chan;
                    1:       v = cfg_rate;
                    default: v = cfg_power;
                endcase
                fb.push_back(v);
                fb.push_back(8'($urandom_range(255)));
                fb.push_back(8'($urandom_range(255)));
                cur += 3;
            end else if (overrun || cur + 1 <= int'(cfg_limit)) begin
                do v = 8'($urandom_range(255));
                while (v == cfg_wave || v == cfg_chan || v == cfg_rate || v == cfg_power);
                fb.push_back(v);
                cur += 1;
            end else begin
                break;
            end
        end
        fb.push_back(cfg_wave);
        fb.push_back(8'($urandom_range(255)));
        fb.push_back(8'($urandom_range(255)));
        cut       = fb.size();
        mark_last = 1'($urandom_range(1));
        if (roll >= 65 && roll < 82) begin
            cut       = $urandom_range(1, fb.size() - 1);
            mark_last = (roll < 76);
        end
        for (int i = 0; i < cut; i++) add_byte(fb[i], i == 0, mark_last && i == cut - 1);
        frame_bytes_queued += cut;
        // bytes past the end of a complete header are dropped by the block
        if (cut == fb.size() && !mark_last) begin
            repeat ($urandom_range(0, 3))
                add_byte(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
    endtask

    task automatic run_frames(input int count, input int sender_idle, input int receiver_stall);
        @(negedge aclk);
        send_idle_pct      = sender_idle;
        recv_stall_pct     = receiver_stall;
        frame_bytes_queued = 0;
        while (frame_bytes_queued < count) push_frame();
        wait_drained();
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // single-byte frame ends early on its version byte
        add_byte(8'hAB, 1'b1, 1'b1);
        // reserved PSID prefix, then a stray byte to drop
        add_byte(8'hFF, 1'b1, 1'b0);
        add_byte(8'hF5, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b1);
        // four-byte PSID with all three elements, length ends on the frame's last byte
        add_byte(8'h00, 1'b1, 1'b0);
        add_byte(8'hEF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(CHANNEL_RESET, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(POWER_RESET, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0);
        add_byte(RATE_RESET, 1'b0, 1'b0);
        add_byte(8'h01, 1'b0, 1'b0);
        add_byte(8'h00, 1'b0, 1'b0);
        add_byte(WAVE_ID_RESET, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b1);
        // restart in the middle of a PSID drops the partial header
        add_byte(8'h03, 1'b1, 1'b0);
        add_byte(8'h81, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b1, 1'b1);
        wait_drained();

        load_config(WAVE_ID_RESET, CHANNEL_RESET, RATE_RESET, POWER_RESET, LIMIT_RESET);
        run_frames(180, 0, 0);

        load_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 6'($urandom_range(8, 63)));
        run_frames(180, 83, 0);

        load_config(8'h00, 8'hFF, 8'h01, 8'hFE, 6'd63);
        run_frames(180, 0, 83);

        // channel, rate and power share one ID; tightest scan limit
        load_config(8'hAA, 8'h55, 8'h55, 8'h55, 6'd1);
        run_frames(130, 7, 7);

        // wave ID shadows the channel ID; the second half waits for the first to drain
        load_config(8'hFF, 8'hFF, 8'h00, 8'h00, 6'd63);
        run_frames(80, 7, 7);
        run_frames(80, 7, 7);

        load_config(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 6'($urandom_range(4, 40)));
        run_frames(150, 0, 0);

        $display("Transferred %0d bytes over %0d cycles, checked %0d headers", bytes_taken,
                 cycle_count, headers_seen);
        $display("Status mix: ok %0d, bad PSID %0d, no wave ID %0d, short frame %0d",
                 status_count[ST_OK], status_count[ST_BAD_PSID], status_count[ST_NO_WAVE],
                 status_count[ST_SHORT]);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
